>>> rtl/dhc_pkg.sv
package dhc_pkg;

    // Configuration register indexes and reset values.
    localparam int CFG_INDEX_W = 8;
    localparam logic [CFG_INDEX_W-1:0] REG_RANGE_NEAR = 8'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_RANGE_FAR  = 8'd1;
    localparam logic [15:0] RANGE_NEAR_RESET = 16'd500;
    localparam logic [15:0] RANGE_FAR_RESET  = 16'd5800;

    // Divider layout: 16 quotient bits, a fixed number of them per stage.
    localparam int FRAC_W         = 16;
    localparam int DIV_BITS_STAGE = 4;
    localparam int DIV_STAGES     = FRAC_W / DIV_BITS_STAGE;

    // Hue sectors of h6 = 4 * (1 - frac).
    localparam logic [2:0] SECTOR_RED_YELLOW  = 3'd0;
    localparam logic [2:0] SECTOR_YELLOW_GRN  = 3'd1;
    localparam logic [2:0] SECTOR_GRN_CYAN    = 3'd2;
    localparam logic [2:0] SECTOR_CYAN_BLUE   = 3'd3;

    // Payload that travels down the divider stages.
    typedef struct packed {
        logic              blank;   // sample was zero: no reading
        logic              empty;   // far <= near: fraction forced to zero
        logic              sat;     // clamped sample at far end: full fraction
        logic [15:0]       dv;      // divisor, far - near
        logic [15:0]       rem;     // partial remainder, below dv
        logic [FRAC_W-1:0] quot;    // quotient bits developed so far
    } dhc_pipe_t;

    // floor(level * 255 / 65536) for a Q1.16 level of at most one.
    function automatic logic [7:0] level_to_byte(input logic [16:0] level);
        logic [24:0] prod;
        prod = {level, 8'd0} - {8'd0, level};
        return prod[23:16];
    endfunction

endpackage

>>> rtl/dhc_div_stage.sv
module dhc_div_stage
    import dhc_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      advance,
    input  logic      in_valid,
    input  dhc_pipe_t in_data,
    output logic      out_valid,
    output dhc_pipe_t out_data
);

    logic      valid_reg;
    dhc_pipe_t data_reg;
    dhc_pipe_t data_next;
    logic [16:0] shifted [DIV_BITS_STAGE];
    logic [15:0] rem_step [DIV_BITS_STAGE+1];
    logic [DIV_BITS_STAGE-1:0] qbits;

    // Restoring division: one quotient bit per step, DIV_BITS_STAGE steps per stage.
    always_comb begin
        rem_step[0] = in_data.rem;
        for (int k = 0; k < DIV_BITS_STAGE; k++) begin
            shifted[k] = {rem_step[k], 1'b0};
            if (shifted[k] >= {1'b0, in_data.dv}) begin
                rem_step[k+1] = 16'(shifted[k] - {1'b0, in_data.dv});
                qbits[DIV_BITS_STAGE-1-k] = 1'b1;
            end else begin
                rem_step[k+1] = shifted[k][15:0];
                qbits[DIV_BITS_STAGE-1-k] = 1'b0;
            end
        end
        data_next      = in_data;
        data_next.rem  = rem_step[DIV_BITS_STAGE];
        data_next.quot = {in_data.quot[FRAC_W-DIV_BITS_STAGE-1:0], qbits};
    end

    // Valid bit follows the global pipeline advance.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (advance) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

>>> rtl/depth_to_hue_colormap_core.sv
// Pipeline: range stage, four divider stages of four quotient bits each, color
// output register.
// Throughput: one pixel per cycle; the whole pipeline holds while the output
// register is full and m_tready is low.
// Reset: synchronous, active low; clears all valid bits and loads range_near = 500
// and range_far = 5800. Configuration writes are taken in every cycle.
module depth_to_hue_colormap_core
    import dhc_pkg::*;
(
    input  logic                   aclk,
    input  logic                   aresetn,
    // Depth stream in.
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [15:0]            s_tdata,    // [15:0] depth_sample
    // Pixel stream out.
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [23:0]            m_tdata,    // [7:0] red, [15:8] green, [23:16] blue
    // Configuration writes.
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [15:0]            cfg_data
);

    logic [15:0] range_near_reg;
    logic [15:0] range_far_reg;
    logic        advance;

    logic        in_valid_reg;
    dhc_pipe_t   in_data_reg;
    dhc_pipe_t   in_data_next;
    logic [15:0] clamp_hi;
    logic [15:0] clamp_c;

    logic      stage_valid [DIV_STAGES+1];
    dhc_pipe_t stage_data  [DIV_STAGES+1];

    logic              out_valid_reg;
    logic [23:0]       out_data_reg;
    logic [23:0]       out_data_next;
    logic [FRAC_W-1:0] frac;
    logic [16:0]       one_minus;
    logic [18:0]       h6;
    logic [16:0]       lvl_up;
    logic [16:0]       lvl_down;
    logic [16:0]       lvl_r;
    logic [16:0]       lvl_g;
    logic [16:0]       lvl_b;

    localparam logic [16:0] LEVEL_ONE = 17'h10000;

    // The pipeline moves whenever the output register is free or being taken.
    assign advance   = !out_valid_reg || m_tready;
    assign s_tready  = advance;
    assign cfg_ready = 1'b1;

    // Configuration registers; unknown indexes are ignored.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            range_near_reg <= RANGE_NEAR_RESET;
            range_far_reg  <= RANGE_FAR_RESET;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                REG_RANGE_NEAR: range_near_reg <= cfg_data;
                REG_RANGE_FAR:  range_far_reg  <= cfg_data;
                default: ;
            endcase
        end
    end

    // Range stage: clamp (far first, then near), form dividend and divisor.
    always_comb begin
        clamp_hi = (s_tdata > range_far_reg) ? range_far_reg : s_tdata;
        clamp_c  = (clamp_hi < range_near_reg) ? range_near_reg : clamp_hi;
        in_data_next.blank = (s_tdata == 16'd0);
        in_data_next.empty = !(range_far_reg > range_near_reg);
        in_data_next.dv    = range_far_reg - range_near_reg;
        in_data_next.sat   = !in_data_next.empty
                             && ((clamp_c - range_near_reg) == in_data_next.dv);
        in_data_next.rem   = (in_data_next.sat || in_data_next.empty)
                             ? 16'd0 : (clamp_c - range_near_reg);
        in_data_next.quot  = '0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (advance) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            in_data_reg <= in_data_next;
        end
    end

    assign stage_valid[0] = in_valid_reg;
    assign stage_data[0]  = in_data_reg;

    // Divider stages.
    for (genvar i = 0; i < DIV_STAGES; i++) begin : g_div
        dhc_div_stage u_div_stage (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .advance   (advance),
            .in_valid  (stage_valid[i]),
            .in_data   (stage_data[i]),
            .out_valid (stage_valid[i+1]),
            .out_data  (stage_data[i+1])
        );
    end

    // Color stage: fraction to hue sector and levels, levels to bytes.
    always_comb begin
        if (stage_data[DIV_STAGES].empty) begin
            frac = '0;
        end else if (stage_data[DIV_STAGES].sat) begin
            frac = '1;
        end else begin
            frac = stage_data[DIV_STAGES].quot;
        end
        one_minus = LEVEL_ONE - {1'b0, frac};
        h6        = {one_minus, 2'b00};
        lvl_up    = {1'b0, h6[15:0]};
        lvl_down  = LEVEL_ONE - lvl_up;
        case (h6[18:16])
            SECTOR_RED_YELLOW: begin
                lvl_r = LEVEL_ONE; lvl_g = lvl_up;    lvl_b = '0;
            end
            SECTOR_YELLOW_GRN: begin
                lvl_r = lvl_down;  lvl_g = LEVEL_ONE; lvl_b = '0;
            end
            SECTOR_GRN_CYAN: begin
                lvl_r = '0;        lvl_g = LEVEL_ONE; lvl_b = lvl_up;
            end
            SECTOR_CYAN_BLUE: begin
                lvl_r = '0;        lvl_g = lvl_down;  lvl_b = LEVEL_ONE;
            end
            default: begin
                lvl_r = lvl_up;    lvl_g = '0;        lvl_b = LEVEL_ONE;
            end
        endcase
        if (stage_data[DIV_STAGES].blank) begin
            out_data_next = '0;
        end else begin
            out_data_next = {level_to_byte(lvl_b), level_to_byte(lvl_g),
                             level_to_byte(lvl_r)};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= stage_valid[DIV_STAGES];
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_data_reg <= out_data_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    // A waiting result blocks new input transfers.
    a_stall_blocks_input: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |-> !s_tready)
        else $error("input accepted while output stalled");

    // A zero sample leaving the divider becomes a black pixel.
    a_blank_black: assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && stage_valid[DIV_STAGES] && stage_data[DIV_STAGES].blank)
        |=> (m_tdata == 24'd0))
        else $error("no-reading sample did not give black");

    // The partial remainder stays below the divisor in a normal division.
    a_rem_below_dv: assert property (@(posedge aclk) disable iff (!aresetn)
        (stage_valid[DIV_STAGES] && !stage_data[DIV_STAGES].empty)
        |-> (stage_data[DIV_STAGES].rem < stage_data[DIV_STAGES].dv
             || stage_data[DIV_STAGES].sat))
        else $error("divider remainder out of range");

    // Reset leaves no result pending.
    a_reset_clears: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("output valid after reset");

endmodule
